[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

[src/ssk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared types and constants of the smallest-k tracker.
// ----------------------------------------------------------------------------
package ssk_pkg;

  localparam int ValueW      = 32;
  localparam int CfgW        = 5;
  localparam int MaxKeepDef  = 16;
  localparam logic [CfgW-1:0] KeepCountRst = CfgW'(1);

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CfgW-1:0]          cfg_t;

  // Per-cell controls derived from the fill level
  typedef struct packed {
    logic valid;  // cell holds a kept value
    logic hole;   // cell is the insertion limit
    logic write;  // cell updates this cycle
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StRun  = 2'b01,
    StEmit = 2'b10
  } state_e;

endpackage

[src/ssk_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_in_if
// Input channel: one value word per handshake, with end-of-set flag.
// ----------------------------------------------------------------------------
interface ssk_in_if;
  import ssk_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

[src/ssk_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_out_if
// Output channel: one kept value word per handshake, with status flags.
// ----------------------------------------------------------------------------
interface ssk_out_if;
  import ssk_pkg::*;

  logic   valid;
  logic   ready;
  value_t kept_value;
  logic   last_result;
  logic   too_few;

  modport source (output valid, output kept_value, output last_result,
                  output too_few, input ready);
  modport sink   (input valid, input kept_value, input last_result,
                  input too_few, output ready);
endinterface

[src/streaming_smallest_k_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_smallest_k_tracker_unit
// Keeps the k smallest signed values of a set in a sorted chain of cells and
// streams them out largest first when the last value of the set arrives.
// Throughput: one value word per cycle in the run state, none while results
// drain; each cell compares and shifts as a word is taken. After the last
// value, the emit state loads k output words into the output register, one
// per cycle while the sink is ready (one word for a too-few set); the next
// value is taken in the cycle after the final word is loaded.
// Reset (async, active low): empty chain, idle output, keep_count = 1.
// ----------------------------------------------------------------------------
module streaming_smallest_k_tracker_unit #(
  parameter int MaxKeep = ssk_pkg::MaxKeepDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  ssk_pkg::cfg_t cfg_wdata_i,
  ssk_in_if.sink        in_i,
  ssk_out_if.source     out_o
);
  import ssk_pkg::*;

  localparam int CntW = $clog2(MaxKeep + 1);
  localparam int IdxW = (MaxKeep > 1) ? $clog2(MaxKeep) : 1;

  cfg_t             keep_q;
  logic [CntW-1:0]  k_eff;
  logic [CntW-1:0]  held_q, held_d, held_eff, held_new, hole_idx;
  logic [CntW-1:0]  emit_cnt_q, emit_cnt_d, emit_top;
  logic             few_q, few_d, few_new;
  logic             room, top_gt, do_ins, in_acc, emit_load;
  state_e           state_q, state_d;

  value_t           cell_val [MaxKeep];
  value_t           left_val [MaxKeep];
  logic [MaxKeep-1:0] cell_gt, left_gt;
  cell_ctrl_t       cell_ctrl [MaxKeep];

  logic             out_valid_q, out_valid_d;
  value_t           out_value_q, out_value_d;
  logic             out_last_q, out_last_d, out_few_q, out_few_d;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KeepCountRst;
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  // Clamp k into 1..MaxKeep
  always_comb begin
    if (keep_q == '0) begin
      k_eff = CntW'(1);
    end else if (int'(keep_q) > MaxKeep) begin
      k_eff = CntW'(MaxKeep);
    end else begin
      k_eff = CntW'(keep_q);
    end
  end

  // Fill level, insertion limit and decision to insert
  assign held_eff = (held_q > k_eff) ? k_eff : held_q;
  assign room     = held_eff < k_eff;
  assign hole_idx = room ? held_eff : held_eff - CntW'(1);
  assign top_gt   = cell_gt[hole_idx[IdxW-1:0]];
  assign in_acc   = in_i.valid && in_i.ready;
  assign do_ins   = in_acc && (room || top_gt);
  assign held_new = room ? held_eff + CntW'(1) : held_eff;
  assign few_new  = held_new < k_eff;

  assign in_i.ready = (state_q == StRun);

  // Row of cells
  for (genvar i = 0; i < MaxKeep; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_val[i] = '0;
      assign left_gt[i]  = 1'b0;
    end else begin : g_body
      assign left_val[i] = cell_val[i-1];
      assign left_gt[i]  = cell_gt[i-1];
    end

    assign cell_ctrl[i].valid = CntW'(i) < held_eff;
    assign cell_ctrl[i].hole  = CntW'(i) == hole_idx;
    assign cell_ctrl[i].write = do_ins && (CntW'(i) <= hole_idx);

    ssk_cell u_cell (
      .clk_i        (clk_i),
      .ins_value_i  (in_i.value),
      .left_value_i (left_val[i]),
      .left_gt_i    (left_gt[i]),
      .ctrl_i       (cell_ctrl[i]),
      .value_o      (cell_val[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // Sequencer: accept values, then drain the chain largest first
  assign emit_top  = emit_cnt_q - CntW'(1);
  assign emit_load = (state_q == StEmit) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    emit_cnt_d  = emit_cnt_q;
    few_d       = few_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_few_d   = out_few_q;
    case (state_q)
      StRun: begin
        if (in_acc && in_i.last_item) begin
          held_d     = '0;
          emit_cnt_d = held_new;
          few_d      = few_new;
          state_d    = StEmit;
        end else if (in_acc) begin
          held_d = held_new;
        end
      end
      StEmit: begin
        if (emit_load) begin
          if (few_q) begin
            out_value_d = '0;
            out_last_d  = 1'b1;
            out_few_d   = 1'b1;
            state_d     = StRun;
          end else begin
            out_value_d = cell_val[emit_top[IdxW-1:0]];
            out_last_d  = (emit_cnt_q == CntW'(1));
            out_few_d   = 1'b0;
            emit_cnt_d  = emit_top;
            if (emit_cnt_q == CntW'(1)) begin
              state_d = StRun;
            end
          end
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  // Output register: set on load, drop once taken
  always_comb begin
    if (emit_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      held_q      <= '0;
      emit_cnt_q  <= '0;
      few_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      emit_cnt_q  <= emit_cnt_d;
      few_q       <= few_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_few_q   <= out_few_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kept_value  = out_value_q;
  assign out_o.last_result = out_last_q;
  assign out_o.too_few     = out_few_q;

endmodule

[src/ssk_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_cell
// One slot of the sorted chain: compares the incoming value against its own
// entry and either keeps it, takes the new value, or takes its left neighbor.
// ----------------------------------------------------------------------------
module ssk_cell (
  input  logic                clk_i,
  input  ssk_pkg::value_t     ins_value_i,
  input  ssk_pkg::value_t     left_value_i,
  input  logic                left_gt_i,
  input  ssk_pkg::cell_ctrl_t ctrl_i,
  output ssk_pkg::value_t     value_o,
  output logic                gt_o
);
  import ssk_pkg::*;

  value_t value_q, value_d;

  // Flag an entry that the new word must go below
  assign gt_o = ctrl_i.valid && (value_q > ins_value_i);

  // Shift up from the left, take the new word, or hold
  always_comb begin
    if (left_gt_i) begin
      value_d = left_value_i;
    end else if (gt_o || ctrl_i.hole) begin
      value_d = ins_value_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

[src/ssk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_checker
// Port-level checks of the smallest-k tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssk_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            in_last_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input ssk_pkg::value_t out_value_i,
  input logic            out_last_i,
  input logic            out_few_i
);
  import ssk_pkg::*;

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // A stalled result word stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // The end of a set stops intake while results drain
  `ASSERT_NEXT(a_last_stops_in, clk_i, rst_ni, in_acc && in_last_i, !in_ready_i)

  // A too-few word is the only and final one, with a zero value
  `ASSERT_SAME(a_few_form, clk_i, rst_ni, out_valid_i && out_few_i,
               out_last_i && (out_value_i == '0))

  // Result words of one run follow without a gap
  `ASSERT_NEXT(a_no_gap, clk_i, rst_ni, out_acc && !out_last_i, out_valid_i)

endmodule

bind streaming_smallest_k_tracker_unit ssk_checker u_ssk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_item),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.kept_value),
  .out_last_i  (out_o.last_result),
  .out_few_i   (out_o.too_few)
);
